FILE: hdl/mbs_pkg.sv
package mbs_pkg;

	// Register values after reset.
	localparam int unsigned RST_COLS      = 63;
	localparam int unsigned RST_ROWS      = 63;
	localparam int unsigned RST_START_COL = 1;
	localparam int unsigned RST_START_ROW = 1;

	// Result event codes.
	typedef enum logic [1:0] {
		EV_CARVE   = 2'd0,
		EV_BACK    = 2'd1,
		EV_RESTART = 2'd2,
		EV_READ    = 2'd3
	} ev_t;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [6:0] cols;
		logic [6:0] rows;
		logic [5:0] start_col;
		logic [5:0] start_row;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       take_in;
		logic       get_tile;
		logic       get_cell;
		logic       nb_rd;
		logic [1:0] nb_idx;
		logic       nb_cap;
		logic [1:0] cap_idx;
		logic       decide;
		logic       carve_pick;
		logic       carve_mid;
		logic       init_pass;
		logic       wipe_pass;
		logic       load_out;
		ev_t        evt;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cmd_read;
		logic stack_empty;
		logic will_carve;
		logic pass_last;
	} dp_sts_t;

	// Remainder of a 16-bit value by three. Four is one modulo three, so the
	// base-four digits are summed twice and the small sum is mapped directly.
	function automatic logic [1:0] mod3_16(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		logic [1:0] r;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		case (t) inside
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4, 3'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/mbs_ram.sv
module mbs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/mbs_ctrl.sv
module mbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  mbs_pkg::dp_sts_t  sts,
	output mbs_pkg::dp_cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_INIT   = 12'b0000_0000_0001,
		S_IDLE   = 12'b0000_0000_0010,
		S_DISP   = 12'b0000_0000_0100,
		S_TILE   = 12'b0000_0000_1000,
		S_CELL   = 12'b0000_0001_0000,
		S_NB     = 12'b0000_0010_0000,
		S_NBL    = 12'b0000_0100_0000,
		S_DEC    = 12'b0000_1000_0000,
		S_CARVE1 = 12'b0001_0000_0000,
		S_CARVE2 = 12'b0010_0000_0000,
		S_WIPE   = 12'b0100_0000_0000,
		S_FIN    = 12'b1000_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [1:0]       nb_q;
	mbs_pkg::ev_t     evt_q;
	logic             rsp_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd         = '0;
		cmd.nb_idx  = nb_q;
		cmd.cap_idx = nb_q - 2'd1;
		cmd.evt     = evt_q;
		state_d     = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.init_pass = 1'b1;
				if (sts.pass_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.cmd_read) begin
					state_d = S_TILE;
				end else if (sts.stack_empty) begin
					state_d = S_WIPE;
				end else begin
					state_d = S_CELL;
				end
			end
			S_TILE: begin
				cmd.get_tile = 1'b1;
				state_d      = S_FIN;
			end
			S_CELL: begin
				cmd.get_cell = 1'b1;
				state_d      = S_NB;
			end
			S_NB: begin
				cmd.nb_rd  = 1'b1;
				cmd.nb_cap = (nb_q != 2'd0);
				if (nb_q == 2'd3) state_d = S_NBL;
			end
			S_NBL: begin
				cmd.nb_cap = 1'b1;
				state_d    = S_DEC;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d    = sts.will_carve ? S_CARVE1 : S_FIN;
			end
			S_CARVE1: begin
				cmd.carve_pick = 1'b1;
				state_d        = S_CARVE2;
			end
			S_CARVE2: begin
				cmd.carve_mid = 1'b1;
				state_d       = S_FIN;
			end
			S_WIPE: begin
				cmd.wipe_pass = 1'b1;
				if (sts.pass_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, neighbor counter and event kind of the request in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			nb_q    <= 2'd0;
			evt_q   <= mbs_pkg::EV_CARVE;
		end else begin
			state_q <= state_d;
			if (state_q == S_NB) nb_q <= nb_q + 2'd1;
			if (state_q == S_DISP) begin
				if (sts.cmd_read) begin
					evt_q <= mbs_pkg::EV_READ;
				end else if (sts.stack_empty) begin
					evt_q <= mbs_pkg::EV_RESTART;
				end else begin
					evt_q <= mbs_pkg::EV_CARVE;
				end
			end else if (state_q == S_DEC && !sts.will_carve) begin
				evt_q <= mbs_pkg::EV_BACK;
			end
		end
	end

	// Result valid: set on load, cleared once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(rsp_valid_q && rsp_stall))
		else $error("result loaded over a waiting result");

	// The last neighbor capture follows the fourth neighbor read.
	a_nb_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NBL |-> ($past(state_q) == S_NB && nb_q == 2'd0))
		else $error("neighbor scan out of order");

endmodule

FILE: hdl/mbs_dp.sv
module mbs_dp #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 64,
	parameter int STACK_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mbs_pkg::cfg_t     cfg,
	input  mbs_pkg::dp_cmd_t  cmd,
	output mbs_pkg::dp_sts_t  sts,
	input  logic              command,
	input  logic [15:0]       random_value,
	input  logic [5:0]        read_col,
	input  logic [5:0]        read_row,
	output logic [1:0]        event_kind,
	output logic [5:0]        cur_col,
	output logic [5:0]        cur_row,
	output logic              tile_is_path,
	output logic [10:0]       stack_level
);

	localparam int CB        = $clog2(MAX_COLS);
	localparam int RB        = $clog2(MAX_ROWS);
	localparam int CW0       = (CB > RB) ? CB : RB;
	localparam int CW        = (CW0 > 6) ? CW0 : 6;
	localparam int NW        = CW + 2;
	localparam int AW        = CB + RB;
	localparam int MAP_DEPTH = 1 << AW;
	localparam int SAW       = $clog2(STACK_DEPTH);
	localparam int CNTW      = $clog2(STACK_DEPTH + 1);
	localparam int STEP      = 2;
	localparam logic [AW-1:0] RST_ADDR =
		{CB'(mbs_pkg::RST_START_COL), RB'(mbs_pkg::RST_START_ROW)};

	// Tile lies inside the grid in use; coordinates are two's complement.
	function automatic logic in_grid(input logic [NW-1:0] c, input logic [NW-1:0] r,
			input mbs_pkg::cfg_t g);
		return !c[NW-1] && !r[NW-1] && (c < NW'(g.cols)) && (r < NW'(g.rows)) &&
			(c < NW'(MAX_COLS)) && (r < NW'(MAX_ROWS));
	endfunction

	function automatic logic [AW-1:0] maddr(input logic [NW-1:0] c, input logic [NW-1:0] r);
		return {c[CB-1:0], r[RB-1:0]};
	endfunction

	// Latched request.
	logic              cmd_q;
	logic [15:0]       rnd_q;
	logic [5:0]        rcol_q, rrow_q;

	// Builder cell, its neighbors and the tiles between.
	logic [CW-1:0]     cell_c_q, cell_r_q;
	logic [NW-1:0]     nbc_q [4];
	logic [NW-1:0]     nbr_q [4];
	logic [NW-1:0]     midc_q [4];
	logic [NW-1:0]     midr_q [4];
	logic [3:0]        nbin_q, midin_q, cand_q;
	logic [NW-1:0]     nbc_d [4];
	logic [NW-1:0]     nbr_d [4];
	logic [NW-1:0]     midc_d [4];
	logic [NW-1:0]     midr_d [4];
	logic [NW-1:0]     top_c, top_r;

	logic [1:0]        sel_q, sel_d, k;
	logic [2:0]        n, seen;
	logic              will_carve;
	logic [CNTW-1:0]   cnt_q;
	logic [AW-1:0]     clr_q;
	logic              tile_q;

	// Memory ports.
	logic              map_we, map_wdata, map_rdata, pass_bit, start_in;
	logic [AW-1:0]     map_waddr, map_raddr, start_addr;
	logic              stk_we;
	logic [SAW-1:0]    stk_waddr, stk_raddr;
	logic [2*CW-1:0]   stk_wdata, stk_rdata, pick_cell, start_cell;
	logic [NW-1:0]     start_c, start_r, rd_c, rd_r;

	mbs_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	mbs_ram #(.WIDTH(2*CW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Request latch.
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			cmd_q  <= command;
			rnd_q  <= random_value;
			rcol_q <= read_col;
			rrow_q <= read_row;
		end
	end

	// Neighbors two tiles away and the tiles between, east, south, west, north.
	always_comb begin
		top_c     = NW'(stk_rdata[2*CW-1:CW]);
		top_r     = NW'(stk_rdata[CW-1:0]);
		nbc_d[0]  = top_c + NW'(STEP);
		nbr_d[0]  = top_r;
		nbc_d[1]  = top_c;
		nbr_d[1]  = top_r + NW'(STEP);
		nbc_d[2]  = top_c - NW'(STEP);
		nbr_d[2]  = top_r;
		nbc_d[3]  = top_c;
		nbr_d[3]  = top_r - NW'(STEP);
		midc_d[0] = top_c + NW'(1);
		midr_d[0] = top_r;
		midc_d[1] = top_c;
		midr_d[1] = top_r + NW'(1);
		midc_d[2] = top_c - NW'(1);
		midr_d[2] = top_r;
		midc_d[3] = top_c;
		midr_d[3] = top_r - NW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.get_cell) begin
			cell_c_q <= stk_rdata[2*CW-1:CW];
			cell_r_q <= stk_rdata[CW-1:0];
			for (int i = 0; i < 4; i++) begin
				nbc_q[i]   <= nbc_d[i];
				nbr_q[i]   <= nbr_d[i];
				midc_q[i]  <= midc_d[i];
				midr_q[i]  <= midr_d[i];
				nbin_q[i]  <= in_grid(nbc_d[i], nbr_d[i], cfg);
				midin_q[i] <= in_grid(midc_d[i], midr_d[i], cfg);
			end
		end
		if (cmd.nb_cap) begin
			cand_q[cmd.cap_idx] <= nbin_q[cmd.cap_idx] & !map_rdata;
		end
		if (cmd.get_tile) begin
			tile_q <= in_grid(rd_c, rd_r, cfg) & map_rdata;
		end
		if (cmd.decide) begin
			sel_q <= sel_d;
		end
	end

	// Candidate count, random pick and the chosen direction.
	always_comb begin
		n = 3'($countones(cand_q));
		case (n)
			3'd2:    k = {1'b0, rnd_q[0]};
			3'd3:    k = mbs_pkg::mod3_16(rnd_q);
			3'd4:    k = rnd_q[1:0];
			default: k = 2'd0;
		endcase
		seen  = 3'd0;
		sel_d = 2'd0;
		for (int j = 0; j < 4; j++) begin
			if (cand_q[j]) begin
				if (seen == {1'b0, k}) sel_d = 2'(j);
				seen = seen + 3'd1;
			end
		end
		will_carve = (n != 3'd0) && (cnt_q < CNTW'(STACK_DEPTH));
	end

	// Stack count: push after carving, pop on backtrack, one after restart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNTW'(1);
		end else if (cmd.wipe_pass) begin
			cnt_q <= CNTW'(1);
		end else if (cmd.carve_mid) begin
			cnt_q <= cnt_q + CNTW'(1);
		end else if (cmd.decide && !will_carve) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	// Clearing pass address, wrapping back to zero after the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.init_pass || cmd.wipe_pass) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Map and stack port steering.
	always_comb begin
		rd_c       = NW'(rcol_q);
		rd_r       = NW'(rrow_q);
		start_c    = NW'(cfg.start_col);
		start_r    = NW'(cfg.start_row);
		start_in   = in_grid(start_c, start_r, cfg);
		start_addr = maddr(start_c, start_r);
		pass_bit   = cmd.init_pass ? (clr_q == RST_ADDR) :
			(start_in && (clr_q == start_addr));
		pick_cell  = {nbc_q[sel_q][CW-1:0], nbr_q[sel_q][CW-1:0]};
		start_cell = cmd.init_pass ?
			{CW'(mbs_pkg::RST_START_COL), CW'(mbs_pkg::RST_START_ROW)} :
			{CW'(cfg.start_col), CW'(cfg.start_row)};

		map_raddr = cmd.nb_rd ? maddr(nbc_q[cmd.nb_idx], nbr_q[cmd.nb_idx]) :
			maddr(rd_c, rd_r);
		map_we    = cmd.init_pass || cmd.wipe_pass || cmd.carve_pick ||
			(cmd.carve_mid && midin_q[sel_q]);
		if (cmd.init_pass || cmd.wipe_pass) begin
			map_waddr = clr_q;
			map_wdata = pass_bit;
		end else if (cmd.carve_pick) begin
			map_waddr = maddr(nbc_q[sel_q], nbr_q[sel_q]);
			map_wdata = 1'b1;
		end else begin
			map_waddr = maddr(midc_q[sel_q], midr_q[sel_q]);
			map_wdata = 1'b1;
		end

		stk_raddr = SAW'(cnt_q - CNTW'(1));
		stk_we    = cmd.init_pass || cmd.wipe_pass || cmd.carve_mid;
		stk_waddr = cmd.carve_mid ? cnt_q[SAW-1:0] : '0;
		stk_wdata = cmd.carve_mid ? pick_cell : start_cell;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			event_kind   <= cmd.evt;
			tile_is_path <= (cmd.evt == mbs_pkg::EV_READ) && tile_q;
			stack_level  <= 11'(cnt_q);
			case (cmd.evt)
				mbs_pkg::EV_CARVE: begin
					cur_col <= nbc_q[sel_q][5:0];
					cur_row <= nbr_q[sel_q][5:0];
				end
				mbs_pkg::EV_BACK: begin
					cur_col <= cell_c_q[5:0];
					cur_row <= cell_r_q[5:0];
				end
				mbs_pkg::EV_RESTART: begin
					cur_col <= cfg.start_col;
					cur_row <= cfg.start_row;
				end
				default: begin
					cur_col <= rcol_q;
					cur_row <= rrow_q;
				end
			endcase
		end
	end

	assign sts.cmd_read    = cmd_q;
	assign sts.stack_empty = (cnt_q == '0);
	assign sts.will_carve  = will_carve;
	assign sts.pass_last   = &clr_q;

	// The stack count stays within the stack.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(STACK_DEPTH))
		else $error("stack count beyond stack depth");

	// A push only happens with room left on the stack.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.carve_mid |-> cnt_q < CNTW'(STACK_DEPTH))
		else $error("push onto a full stack");

	// A backtrack never pops an empty stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && !will_carve) |-> cnt_q != '0)
		else $error("pop of an empty stack");

endmodule

FILE: hdl/maze_backtracker_step.sv
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   command, random_value, read_col, read_row
// result    out        rsp_valid/rsp_stall   event_kind, cur_col, cur_row, tile_is_path,
//                                            stack_level
// config    in         APB psel/penable      paddr, pwdata, prdata (pready tied high)
//
// One request at a time. For a carving step or a backtrack the single map read port
// checks the four neighbors one per cycle. A restart sweeps the whole map, one tile
// a cycle. After reset the same clearing pass runs and req_stall stays high during
// it. A finished result waits in the output register while rsp_stall is high; the next
// request is still taken and waits at its end for the register to be free.
module maze_backtracker_step #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 64,
	parameter int STACK_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        command,
	input  logic [15:0] random_value,
	input  logic [5:0]  read_col,
	input  logic [5:0]  read_row,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  event_kind,
	output logic [5:0]  cur_col,
	output logic [5:0]  cur_row,
	output logic        tile_is_path,
	output logic [10:0] stack_level
);

	typedef enum logic [1:0] {
		R_COLS = 2'd0,
		R_ROWS = 2'd1,
		R_SCOL = 2'd2,
		R_SROW = 2'd3
	} reg_idx_t;

	mbs_pkg::cfg_t    cfg_q;
	mbs_pkg::dp_cmd_t cmd;
	mbs_pkg::dp_sts_t sts;
	logic             cfg_wr;
	reg_idx_t         reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols      <= 7'(mbs_pkg::RST_COLS);
			cfg_q.rows      <= 7'(mbs_pkg::RST_ROWS);
			cfg_q.start_col <= 6'(mbs_pkg::RST_START_COL);
			cfg_q.start_row <= 6'(mbs_pkg::RST_START_ROW);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				R_COLS: cfg_q.cols      <= pwdata[6:0];
				R_ROWS: cfg_q.rows      <= pwdata[6:0];
				R_SCOL: cfg_q.start_col <= pwdata[5:0];
				R_SROW: cfg_q.start_row <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			R_COLS:  prdata = 32'(cfg_q.cols);
			R_ROWS:  prdata = 32'(cfg_q.rows);
			R_SCOL:  prdata = 32'(cfg_q.start_col);
			R_SROW:  prdata = 32'(cfg_q.start_row);
			default: prdata = '0;
		endcase
	end

	mbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbs_dp #(
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.command      (command),
		.random_value (random_value),
		.read_col     (read_col),
		.read_row     (read_row),
		.event_kind   (event_kind),
		.cur_col      (cur_col),
		.cur_row      (cur_row),
		.tile_is_path (tile_is_path),
		.stack_level  (stack_level)
	);

endmodule
